// ----- rtl/core/hot_program_tracker_ranker_macros.svh -----
// Assertion macros shared by the hot program tracker RTL.
`ifndef HOT_PROGRAM_TRACKER_RANKER_MACROS_SVH
`define HOT_PROGRAM_TRACKER_RANKER_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define HPTR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define HPTR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/hptr_pkg.sv -----
// Types and constants of the hot program tracker and ranker.
package hptr_pkg;

	localparam int PC_W    = 14;
	localparam int CYC_W   = 32;
	localparam int SCORE_W = 36;
	localparam int SLOT_W  = 11;
	localparam int CNT_W   = 32;
	localparam int DIST_W  = 12;
	localparam int CFG_W   = 16;

	localparam logic [1:0] CMD_EXEC    = 2'd0;
	localparam logic [1:0] CMD_FRAME   = 2'd1;
	localparam logic [1:0] CMD_TRIGGER = 2'd2;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_CAND   = 2'd1;
	localparam logic [1:0] KIND_NONE   = 2'd2;

	localparam logic [1:0] PHASE_NONE  = 2'd0;
	localparam logic [1:0] PHASE_START = 2'd1;
	localparam logic [1:0] PHASE_END   = 2'd2;

	localparam logic [1:0] REG_ENABLE    = 2'd0;
	localparam logic [1:0] REG_IDLE_THR  = 2'd1;
	localparam logic [1:0] REG_MIN_USES  = 2'd2;

	localparam logic [CFG_W-1:0] IDLE_THR_RST = 16'd60;
	localparam logic [CFG_W-1:0] MIN_USES_RST = 16'd5;
	localparam logic [CNT_W-1:0] AVG_LIMIT    = 32'd1000;
	localparam logic [SCORE_W-1:0] AVG_BONUS  = 36'd50;
	localparam logic [3:0] DECADE_LAST        = 4'd9;

	typedef struct packed {
		logic clear;
		logic insert;
		logic pop;
	} topk_ctrl_t;

endpackage

// ----- rtl/core/hptr_if.sv -----
// Handshake channels for input items and result items.
interface hptr_in_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  cmd;
	logic [hptr_pkg::PC_W-1:0]   pc;
	logic [hptr_pkg::CYC_W-1:0]  cycles;
	modport source (output valid, cmd, pc, cycles, input ready);
	modport sink (input valid, cmd, pc, cycles, output ready);
endinterface

interface hptr_out_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    kind;
	logic [hptr_pkg::PC_W-1:0]     cand_pc;
	logic [hptr_pkg::SCORE_W-1:0]  score;
	logic                          loading;
	logic [1:0]                    phase_change;
	logic [hptr_pkg::DIST_W-1:0]   tracked_count;
	logic                          last;
	modport source (output valid, kind, cand_pc, score, loading, phase_change,
		tracked_count, last, input ready);
	modport sink (input valid, kind, cand_pc, score, loading, phase_change,
		tracked_count, last, output ready);
endinterface

// ----- rtl/core/hptr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hptr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/hptr_topk.sv -----
// Sorted list of the best candidates: parallel insertion and head pop.
module hptr_topk #(
	parameter int TOP_K = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hptr_pkg::topk_ctrl_t           ctrl,
	input  logic [hptr_pkg::SCORE_W-1:0]   ins_score,
	input  logic [hptr_pkg::SLOT_W-1:0]    ins_slot,
	output logic                           head_valid,
	output logic                           next_valid,
	output logic [hptr_pkg::SCORE_W-1:0]   head_score,
	output logic [hptr_pkg::SLOT_W-1:0]    head_slot
);

	logic [TOP_K-1:0]                  v_q;
	logic [hptr_pkg::SCORE_W-1:0]      score_q [TOP_K];
	logic [hptr_pkg::SLOT_W-1:0]       slot_q [TOP_K];
	logic [TOP_K-1:0]                  ge;
	logic [TOP_K-1:0]                  ge_prev;
	logic [TOP_K:0]                    v_ext;

	// Entries that stay ahead of a new score form a prefix of the list, so
	// equal scores keep the earlier (lower) slot in front.
	always_comb begin
		for (int i = 0; i < TOP_K; i++) begin
			ge[i] = v_q[i] && (score_q[i] >= ins_score);
		end
		ge_prev[0] = 1'b1;
		for (int i = 1; i < TOP_K; i++) begin
			ge_prev[i] = ge[i-1];
		end
		v_ext = {1'b0, v_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (ctrl.clear) begin
			v_q <= '0;
		end else if (ctrl.insert) begin
			for (int i = 0; i < TOP_K; i++) begin
				if (!ge[i] && ge_prev[i]) begin
					v_q[i] <= 1'b1;
				end
			end
			for (int i = 1; i < TOP_K; i++) begin
				if (!ge[i] && !ge_prev[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end else if (ctrl.pop) begin
			v_q <= v_ext[TOP_K:1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			for (int i = 0; i < TOP_K; i++) begin
				if (!ge[i] && ge_prev[i]) begin
					score_q[i] <= ins_score;
					slot_q[i]  <= ins_slot;
				end
			end
			for (int i = 1; i < TOP_K; i++) begin
				if (!ge[i] && !ge_prev[i]) begin
					score_q[i] <= score_q[i-1];
					slot_q[i]  <= slot_q[i-1];
				end
			end
		end else if (ctrl.pop) begin
			for (int i = 0; i < TOP_K - 1; i++) begin
				score_q[i] <= score_q[i+1];
				slot_q[i]  <= slot_q[i+1];
			end
		end
	end

	assign head_valid = v_q[0];
	assign next_valid = v_ext[1];
	assign head_score = score_q[0];
	assign head_slot  = slot_q[0];

endmodule

// ----- rtl/core/hot_program_tracker_ranker.sv -----
// Top level of the hot program tracker and ranker.
//
//  port    | direction | transaction
//  in_ch   | sink      | one command: execution, frame tick or ranking trigger
//  out_ch  | source    | one result: status, candidate or empty ranking
//  cfg_*   | write     | one register write, no wait
//
// After reset a clearing pass writes zero to all PROG_SLOTS table rows, one a
// cycle, before the first item is taken. An execution reads the table, writes the
// updated row and emits its result; a frame tick first updates the idle count,
// other commands go straight to their status result. A trigger while loading
// scans the table through the single RAM read port, then emits one result per
// cycle; a stalled output holds the sequencer in its result state.
`include "hot_program_tracker_ranker_macros.svh"

module hot_program_tracker_ranker #(
	parameter int PROG_SLOTS = 2048,
	parameter int TOP_K      = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	hptr_in_if.sink                     in_ch,
	hptr_out_if.source                  out_ch,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [hptr_pkg::CFG_W-1:0]  cfg_data
);

	localparam int AW = $clog2(PROG_SLOTS);
	localparam int RW = 2 * hptr_pkg::CNT_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(PROG_SLOTS - 1);
	localparam logic [AW:0]   SLOTS_C   = (AW + 1)'(PROG_SLOTS);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_EXEC  = 7'b0000100,
		S_FRAME = 7'b0001000,
		S_STAT  = 7'b0010000,
		S_SCAN  = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;

	logic                            en_q;
	logic [hptr_pkg::CFG_W-1:0]      idle_thr_q;
	logic [hptr_pkg::CFG_W-1:0]      min_uses_q;

	logic [hptr_pkg::CNT_W-1:0]      idle_frames_q;
	logic [3:0]                      decade_q;
	logic                            loading_q;
	logic [hptr_pkg::DIST_W-1:0]     distinct_q;
	logic [1:0]                      phase_q;

	logic [hptr_pkg::PC_W-1:0]       pc_q;
	logic [hptr_pkg::CYC_W-1:0]      cyc_q;
	logic [AW-1:0]                   clr_q;
	logic [AW:0]                     scan_q;

	logic                            rd_v_s1;
	logic [AW-1:0]                   rd_addr_s1;
	logic                            v_s2;
	logic                            ok_s2;
	logic [hptr_pkg::SCORE_W-1:0]    sc_s2;
	logic [hptr_pkg::SLOT_W-1:0]     slot_s2;

	logic                            out_v_q;
	logic [1:0]                      kind_q;
	logic [hptr_pkg::PC_W-1:0]       cand_pc_q;
	logic [hptr_pkg::SCORE_W-1:0]    score_q;
	logic                            loading_out_q;
	logic [1:0]                      phase_out_q;
	logic [hptr_pkg::DIST_W-1:0]     tracked_q;
	logic                            last_q;

	logic                            in_acc;
	logic                            out_free;
	logic                            out_load;
	logic                            in_range;
	logic [AW-1:0]                   exec_addr;
	logic [AW-1:0]                   in_addr;
	logic                            issue;
	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [RW-1:0]                   ram_wdata;
	logic [AW-1:0]                   ram_raddr;
	logic [RW-1:0]                   ram_rdata;
	logic [hptr_pkg::CNT_W-1:0]      use_rd;
	logic [hptr_pkg::CNT_W-1:0]      avg_rd;
	logic [hptr_pkg::CNT_W-1:0]      use_nx;
	logic [hptr_pkg::CNT_W-1:0]      avg_nx;
	logic [hptr_pkg::CYC_W+2:0]      avg_sum;
	logic [hptr_pkg::CNT_W-1:0]      idle_nx;
	logic [3:0]                      decade_nx;
	logic                            frame_now;
	logic [hptr_pkg::SCORE_W-1:0]    sc_rd;
	logic                            ok_rd;
	logic [31:0]                     in_slot32;
	logic [31:0]                     exec_slot32;
	logic [31:0]                     rd_addr32;
	logic                            head_valid;
	logic                            next_valid;
	logic [hptr_pkg::SCORE_W-1:0]    head_score;
	logic [hptr_pkg::SLOT_W-1:0]     head_slot;
	hptr_pkg::topk_ctrl_t            tk_ctrl;

	function automatic logic [1:0] phase_of(input logic now, input logic cur);
		logic [1:0] p;
		if (now == cur) begin
			p = hptr_pkg::PHASE_NONE;
		end else if (now) begin
			p = hptr_pkg::PHASE_START;
		end else begin
			p = hptr_pkg::PHASE_END;
		end
		return p;
	endfunction

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_free = !out_v_q || out_ch.ready;
	assign out_load = ((state_q == S_STAT) || (state_q == S_EMIT)) && out_free;
	assign in_ch.ready = (state_q == S_IDLE);

	assign in_slot32   = 32'(in_ch.pc[hptr_pkg::PC_W-1:3]);
	assign exec_slot32 = 32'(pc_q[hptr_pkg::PC_W-1:3]);
	assign in_addr     = in_slot32[AW-1:0];
	assign exec_addr   = exec_slot32[AW-1:0];
	assign in_range    = exec_slot32 < 32'(PROG_SLOTS);
	assign issue       = (state_q == S_SCAN) && (scan_q < SLOTS_C);
	assign rd_addr32   = 32'(rd_addr_s1);

	assign use_rd = ram_rdata[RW-1:hptr_pkg::CNT_W];
	assign avg_rd = ram_rdata[hptr_pkg::CNT_W-1:0];

	// Table update of an execution; the 3:1 average is exact in 35 bits.
	always_comb begin
		use_nx  = (use_rd == '1) ? use_rd : use_rd + 1'b1;
		avg_sum = 35'({avg_rd, 1'b0}) + 35'(avg_rd) + 35'(cyc_q);
		avg_nx  = (avg_rd == '0) ? cyc_q : avg_sum[hptr_pkg::CYC_W+1:2];
	end

	always_comb begin
		idle_nx   = (idle_frames_q == '1) ? idle_frames_q : idle_frames_q + 1'b1;
		decade_nx = (decade_q >= hptr_pkg::DECADE_LAST) ? 4'd0 : decade_q + 4'd1;
		frame_now = idle_nx >= 32'(idle_thr_q);
	end

	// Score of the row read during the scan: uses * 10 plus the slow bonus.
	always_comb begin
		sc_rd = {1'b0, use_rd, 3'b000} + {3'b000, use_rd, 1'b0};
		if (avg_rd > hptr_pkg::AVG_LIMIT) begin
			sc_rd = sc_rd + hptr_pkg::AVG_BONUS;
		end
		ok_rd = (use_rd != '0) && (use_rd >= 32'(min_uses_q));
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == S_EXEC) begin
			ram_we    = in_range;
			ram_waddr = exec_addr;
			ram_wdata = {use_nx, avg_nx};
		end
		ram_raddr = (state_q == S_SCAN) ? scan_q[AW-1:0] : in_addr;
	end

	hptr_ram #(
		.WIDTH(RW),
		.DEPTH(PROG_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		tk_ctrl.clear  = in_acc && (in_ch.cmd == hptr_pkg::CMD_TRIGGER);
		tk_ctrl.insert = v_s2 && ok_s2;
		tk_ctrl.pop    = (state_q == S_EMIT) && out_free && head_valid;
	end

	hptr_topk #(
		.TOP_K(TOP_K)
	) u_topk (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (tk_ctrl),
		.ins_score  (sc_s2),
		.ins_slot   (slot_s2),
		.head_valid (head_valid),
		.next_valid (next_valid),
		.head_score (head_score),
		.head_slot  (head_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q       <= 1'b1;
			idle_thr_q <= hptr_pkg::IDLE_THR_RST;
			min_uses_q <= hptr_pkg::MIN_USES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				hptr_pkg::REG_ENABLE:   en_q       <= cfg_data[0];
				hptr_pkg::REG_IDLE_THR: idle_thr_q <= cfg_data;
				hptr_pkg::REG_MIN_USES: min_uses_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			scan_q        <= '0;
			idle_frames_q <= '0;
			decade_q      <= '0;
			loading_q     <= 1'b0;
			distinct_q    <= '0;
			phase_q       <= hptr_pkg::PHASE_NONE;
			rd_v_s1       <= 1'b0;
			v_s2          <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			v_s2    <= rd_v_s1;
			out_v_q <= out_load || (out_v_q && !out_ch.ready);
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						phase_q <= hptr_pkg::PHASE_NONE;
						scan_q  <= '0;
						if (en_q && in_ch.cmd == hptr_pkg::CMD_EXEC) begin
							state_q <= S_EXEC;
						end else if (en_q && in_ch.cmd == hptr_pkg::CMD_FRAME) begin
							state_q <= S_FRAME;
						end else if (en_q && loading_q &&
							in_ch.cmd == hptr_pkg::CMD_TRIGGER) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_STAT;
						end
					end
				end
				S_EXEC: begin
					if (in_range && use_rd == '0 && distinct_q != '1) begin
						distinct_q <= distinct_q + 1'b1;
					end
					idle_frames_q <= '0;
					decade_q      <= '0;
					loading_q     <= (idle_thr_q == '0);
					phase_q       <= phase_of(idle_thr_q == '0, loading_q);
					state_q       <= S_STAT;
				end
				S_FRAME: begin
					idle_frames_q <= idle_nx;
					decade_q      <= decade_nx;
					if (decade_nx == 4'd0) begin
						loading_q <= frame_now;
						phase_q   <= phase_of(frame_now, loading_q);
					end
					state_q <= S_STAT;
				end
				S_STAT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end else if (!rd_v_s1 && !v_s2) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (!head_valid || !next_valid) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pc_q       <= in_acc ? in_ch.pc : pc_q;
		cyc_q      <= in_acc ? in_ch.cycles : cyc_q;
		rd_addr_s1 <= scan_q[AW-1:0];
		sc_s2      <= sc_rd;
		ok_s2      <= ok_rd;
		slot_s2    <= rd_addr32[hptr_pkg::SLOT_W-1:0];
		if (state_q == S_STAT && out_free) begin
			kind_q        <= hptr_pkg::KIND_STATUS;
			cand_pc_q     <= '0;
			score_q       <= '0;
			loading_out_q <= loading_q;
			phase_out_q   <= phase_q;
			tracked_q     <= distinct_q;
			last_q        <= 1'b1;
		end else if (state_q == S_EMIT && out_free) begin
			kind_q        <= head_valid ? hptr_pkg::KIND_CAND : hptr_pkg::KIND_NONE;
			cand_pc_q     <= head_valid ? {head_slot, 3'b000} : '0;
			score_q       <= head_valid ? head_score : '0;
			loading_out_q <= loading_q;
			phase_out_q   <= hptr_pkg::PHASE_NONE;
			tracked_q     <= distinct_q;
			last_q        <= !head_valid || !next_valid;
		end
	end

	assign out_ch.valid         = out_v_q;
	assign out_ch.kind          = kind_q;
	assign out_ch.cand_pc       = cand_pc_q;
	assign out_ch.score         = score_q;
	assign out_ch.loading       = loading_out_q;
	assign out_ch.phase_change  = phase_out_q;
	assign out_ch.tracked_count = tracked_q;
	assign out_ch.last          = last_q;

	`HPTR_ASSERT_IMP(a_no_take_in_clear, state_q == S_CLEAR, !in_ch.ready,
		"item taken during the clearing pass")
	`HPTR_ASSERT_NXT(a_busy_after_take, in_acc, state_q != S_IDLE,
		"sequencer did not leave idle after a transaction")
	`HPTR_ASSERT_IMP(a_phase_only_status, out_v_q && kind_q != hptr_pkg::KIND_STATUS,
		phase_out_q == hptr_pkg::PHASE_NONE, "phase change on a ranking result")
	`HPTR_ASSERT_IMP(a_write_only_update, ram_we && state_q != S_CLEAR,
		state_q == S_EXEC && in_range, "table written outside an update")

endmodule

// ----- test/hptr_scoreboard.sv -----
// Result predictor and scoreboard for the hot program tracker and ranker.
`timescale 1ns / 1ps

module hptr_scoreboard
	import hptr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	hptr_in_if                in_ch,
	hptr_out_if               out_ch,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output int                pending,
	output int                failures
);

	localparam int SLOTS = 2048;
	localparam int RANK_DEPTH = 16;

	typedef struct packed {
		logic [1:0]         kind;
		logic [PC_W-1:0]    cand_pc;
		logic [SCORE_W-1:0] score;
		logic               loading;
		logic [1:0]         phase_change;
		logic [DIST_W-1:0]  tracked_count;
		logic               last;
	} result_t;

	result_t expected_results[$];

	logic [CNT_W-1:0]  uses[SLOTS];
	logic [CNT_W-1:0]  avg_cyc[SLOTS];
	logic [31:0]       idle_count;
	logic [3:0]        decade;
	logic              loading_now;
	logic [DIST_W-1:0] distinct;
	logic              en;
	logic [CFG_W-1:0]  idle_thr;
	logic [CFG_W-1:0]  min_use_cnt;

	assign pending = expected_results.size();

	task automatic report_mismatch(input string what);
		$display("%0t: %s", $realtime, what);
		failures++;
	endtask

	function automatic void expect_result(result_t r);
		expected_results = {expected_results, r};
	endfunction

	function automatic result_t make_result(logic [1:0] kind, logic [PC_W-1:0] pc,
			logic [SCORE_W-1:0] score, logic [1:0] phase, logic last);
		result_t r;
		r.kind = kind;
		r.cand_pc = pc;
		r.score = score;
		r.loading = loading_now;
		r.phase_change = phase;
		r.tracked_count = distinct;
		r.last = last;
		return r;
	endfunction

	function automatic logic [1:0] update_loading();
		logic now;
		now = idle_count >= {16'd0, idle_thr};
		if (now == loading_now)
			return PHASE_NONE;
		loading_now = now;
		return now ? PHASE_START : PHASE_END;
	endfunction

	// Insertion into a sorted list: a later slot never passes an equal score.
	function automatic void rank_hot_programs();
		logic [SCORE_W-1:0] best_score[RANK_DEPTH];
		int best_slot[RANK_DEPTH];
		logic [SCORE_W-1:0] sc;
		int n;
		int p;
		n = 0;
		for (int s = 0; s < SLOTS; s++) begin
			if (uses[s] == 0 || uses[s] < {16'd0, min_use_cnt})
				continue;
			sc = SCORE_W'(uses[s]) * 10;
			if (avg_cyc[s] > AVG_LIMIT)
				sc += AVG_BONUS;
			p = n;
			while (p > 0 && best_score[p-1] < sc)
				p--;
			if (p >= RANK_DEPTH)
				continue;
			if (n < RANK_DEPTH)
				n++;
			for (int q = n - 1; q > p; q--) begin
				best_score[q] = best_score[q-1];
				best_slot[q] = best_slot[q-1];
			end
			best_score[p] = sc;
			best_slot[p] = s;
		end
		if (n == 0)
			expect_result(make_result(KIND_NONE, '0, '0, PHASE_NONE, 1'b1));
		for (int i = 0; i < n; i++)
			expect_result(make_result(KIND_CAND, PC_W'(best_slot[i] * 8),
				best_score[i], PHASE_NONE, i == n - 1));
	endfunction

	function automatic void predict_command(logic [1:0] cmd, logic [PC_W-1:0] pc,
			logic [CYC_W-1:0] cyc);
		logic [1:0] phase;
		int slot;
		phase = PHASE_NONE;
		slot = pc >> 3;
		if (cmd == CMD_EXEC && en) begin
			if (uses[slot] == 0 && distinct != '1)
				distinct++;
			if (uses[slot] != '1)
				uses[slot]++;
			if (avg_cyc[slot] == 0)
				avg_cyc[slot] = cyc;
			else
				avg_cyc[slot] = 32'(({32'd0, avg_cyc[slot]} * 3 + {32'd0, cyc}) / 4);
			idle_count = 0;
			decade = 0;
			phase = update_loading();
		end else if (cmd == CMD_FRAME && en) begin
			if (idle_count != '1)
				idle_count++;
			decade = (decade >= DECADE_LAST) ? 4'd0 : decade + 4'd1;
			if (decade == 0)
				phase = update_loading();
		end else if (cmd == CMD_TRIGGER && en && loading_now) begin
			rank_hot_programs();
			return;
		end
		expect_result(make_result(KIND_STATUS, '0, '0, phase, 1'b1));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				uses[s] = '0;
				avg_cyc[s] = '0;
			end
			idle_count = '0;
			decade = '0;
			loading_now = 1'b0;
			distinct = '0;
			en = 1'b1;
			idle_thr = IDLE_THR_RST;
			min_use_cnt = MIN_USES_RST;
			failures = 0;
			expected_results.delete();
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.kind, out_ch.cand_pc, out_ch.score, out_ch.loading,
					out_ch.phase_change, out_ch.tracked_count, out_ch.last};
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result %p", got));
				end else begin
					want = expected_results.pop_front();
					if (got.kind !== want.kind)
						report_mismatch($sformatf("kind %0d, expected %0d",
							got.kind, want.kind));
					if (got.cand_pc !== want.cand_pc)
						report_mismatch($sformatf("cand_pc %0d, expected %0d",
							got.cand_pc, want.cand_pc));
					if (got.score !== want.score)
						report_mismatch($sformatf("score %0d, expected %0d",
							got.score, want.score));
					if (got.loading !== want.loading)
						report_mismatch($sformatf("loading %0d, expected %0d",
							got.loading, want.loading));
					if (got.phase_change !== want.phase_change)
						report_mismatch($sformatf("phase_change %0d, expected %0d",
							got.phase_change, want.phase_change));
					if (got.tracked_count !== want.tracked_count)
						report_mismatch($sformatf("tracked_count %0d, expected %0d",
							got.tracked_count, want.tracked_count));
					if (got.last !== want.last)
						report_mismatch($sformatf("last %0d, expected %0d",
							got.last, want.last));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_ENABLE: en = cfg_data[0];
					REG_IDLE_THR: idle_thr = cfg_data;
					REG_MIN_USES: min_use_cnt = cfg_data;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				predict_command(in_ch.cmd, in_ch.pc, in_ch.cycles);
		end
	end

endmodule

// ----- test/tb_hot_program_tracker_ranker.sv -----
// Testbench top: clock, reset, stimulus and verdict for the hot program tracker.
`timescale 1ns / 1ps

module tb_hot_program_tracker_ranker;
	import hptr_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	int                pending;
	int                failures;
	int                send_idle_pct;
	int                recv_stall_pct;
	logic [10:0]       hot_slots[20];

	hptr_in_if  in_ch();
	hptr_out_if out_ch();

	hot_program_tracker_ranker dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	hptr_scoreboard scoreboard (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending), .failures(failures)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(negedge clk)
		out_ch.ready = $urandom_range(99) >= recv_stall_pct;

	task automatic send_cmd(input logic [1:0] cmd, input logic [PC_W-1:0] pc,
			input logic [CYC_W-1:0] cyc);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.cmd = cmd;
		in_ch.pc = pc;
		in_ch.cycles = cyc;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	// Waits until every result is in, then lets the sequencer settle.
	task automatic drain();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
		drain();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] pick_setting();
		case ($urandom_range(5))
			0: return '0;
			1: return 16'd1;
			2: return 16'd2;
			3: return 16'd3;
			4: return '1;
			default: return CFG_W'($urandom_range(6));
		endcase
	endfunction

	task automatic random_item();
		int sel;
		logic [CYC_W-1:0] cyc;
		logic [PC_W-1:0] pc;
		sel = $urandom_range(99);
		pc = {hot_slots[$urandom_range(19)], 3'($urandom)};
		if ($urandom_range(9) == 0)
			pc = PC_W'($urandom);
		case ($urandom_range(3))
			0: cyc = $urandom;
			1: cyc = $urandom_range(1200, 800);
			2: cyc = $urandom_range(20);
			default: cyc = $urandom_range(5000);
		endcase
		if (sel < 38)
			send_cmd(CMD_EXEC, pc, cyc);
		else if (sel < 84)
			send_cmd(CMD_FRAME, PC_W'($urandom), $urandom);
		else if (sel < 96)
			send_cmd(CMD_TRIGGER, PC_W'($urandom), $urandom);
		else
			send_cmd(CMD_UNUSED, PC_W'($urandom), $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_EXEC;
		in_ch.pc = '0;
		in_ch.cycles = '0;
		send_idle_pct = 18;
		recv_stall_pct = 56;
		for (int i = 0; i < 20; i++)
			hot_slots[i] = 11'($urandom);
		hot_slots[0] = '0;
		hot_slots[1] = '1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings first: first runs, table edges, a trigger outside loading.
		send_cmd(CMD_EXEC, '0, '0);
		send_cmd(CMD_EXEC, '1, '1);
		send_cmd(CMD_EXEC, 14'd7, 32'd2000);
		send_cmd(CMD_FRAME, '0, '0);
		send_cmd(CMD_TRIGGER, '0, '0);
		send_cmd(CMD_UNUSED, '1, '1);
		write_reg(REG_IDLE_THR, '0);
		send_cmd(CMD_EXEC, 14'd8, 32'd1001);
		send_cmd(CMD_TRIGGER, '0, '0);
		write_reg(REG_MIN_USES, 16'd1);
		send_cmd(CMD_TRIGGER, '0, '0);
		write_reg(REG_IDLE_THR, '1);
		repeat (10) send_cmd(CMD_FRAME, '0, '0);
		write_reg(REG_ENABLE, 16'd0);
		send_cmd(CMD_EXEC, 14'd16, 32'd5);
		send_cmd(CMD_FRAME, '0, '0);
		send_cmd(CMD_TRIGGER, '0, '0);
		write_reg(REG_ENABLE, 16'd1);
		write_reg(REG_MIN_USES, '0);
		write_reg(REG_IDLE_THR, '0);
		send_cmd(CMD_EXEC, 14'd24, 32'd999);
		send_cmd(CMD_TRIGGER, '0, '0);

		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 18 : (mode == 1) ? 56 : 0;
			recv_stall_pct = (mode == 0) ? 56 : (mode == 1) ? 18 : 0;
			for (int part = 0; part < 3; part++) begin
				write_reg(REG_ENABLE, CFG_W'($urandom_range(5) != 0));
				write_reg(REG_IDLE_THR, pick_setting());
				write_reg(REG_MIN_USES, pick_setting());
				repeat (35) random_item();
			end
		end
		drain();

		if (failures == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#40ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
